// ----- design/ipv4dq_pkg.sv -----
// Package for the IPv4 dotted-quad checker: status codes, character codes and limits.
// Used by ipv4_dotted_quad_checker_unit and its bench; depends on nothing else.
`default_nettype none

package ipv4dq_pkg;

  // Status of one checked address
  typedef enum logic [3:0] {
    StValid    = 4'd0,
    StLength   = 4'd1,
    StLeadZero = 4'd2,
    StOver     = 4'd3,
    StDigits   = 4'd4,
    StEmpty    = 4'd5,
    StDots     = 4'd6,
    StChar     = 4'd7,
    StForm     = 4'd8
  } status_e;

  // Character codes
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChDot  = 8'h2E;

  // Length limits and counter saturation
  localparam logic [4:0] LenMin = 5'd7;
  localparam logic [4:0] LenMax = 5'd15;
  localparam logic [4:0] LenSat = 5'd16;

  // Largest octet value
  localparam logic [11:0] OctetMax = 12'd255;

endpackage

`default_nettype wire

// ----- design/ipv4_dotted_quad_checker_unit.sv -----
// IPv4 dotted-quad checker: one address character per word, status on the last.
// The status word is registered and appears in the cycle after the last character is taken.
// Throughput: one character per cycle; the scan state and the status register
//   are updated in one pass, and the input stalls only while a status waits.
// Reset: all scan state and the status register are cleared at once.
// Depends on ipv4dq_pkg.
`default_nettype none

module ipv4_dotted_quad_checker_unit
  import ipv4dq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  input  wire logic       s_axis_tlast_i,   // last_char
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o    // [3:0] status, [7:4] zero
);

  // Scan state
  logic [4:0] char_cnt_q,  char_cnt_d;
  logic [1:0] dot_cnt_q,   dot_cnt_d;
  logic [7:0] octet_q,     octet_d;
  logic [1:0] digit_cnt_q, digit_cnt_d;
  status_e    err_q,       err_d;

  // Result register
  logic    out_valid_q, out_valid_d;
  status_e status_q,    status_d;

  logic       in_acc;
  logic       is_digit;
  logic [3:0] digit_val;
  logic [11:0] octet_ext;
  logic [11:0] octet_next;
  logic [4:0] char_cnt_inc;
  status_e    status_calc;

  // Take a word whenever the result slot is empty or being emptied
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign is_digit   = (s_axis_tdata_i >= ChZero) && (s_axis_tdata_i <= ChNine);
  assign digit_val  = 4'(s_axis_tdata_i - ChZero);
  assign octet_ext  = {4'b0, octet_q};
  // Times ten as two shifts and an add
  assign octet_next = (octet_ext << 3) + (octet_ext << 1) + {8'b0, digit_val};

  assign char_cnt_inc = (char_cnt_q < LenSat) ? char_cnt_q + 5'd1 : char_cnt_q;

  // Advance the scan by one character
  always_comb begin
    dot_cnt_d   = dot_cnt_q;
    octet_d     = octet_q;
    digit_cnt_d = digit_cnt_q;
    err_d       = err_q;
    if (err_q == StValid) begin
      if (is_digit) begin
        if (digit_cnt_q == 2'd1 && octet_q == 8'd0) begin
          err_d = StLeadZero;
        end else if (octet_next > OctetMax) begin
          err_d = StOver;
        end else if (digit_cnt_q == 2'd3) begin
          err_d = StDigits;
        end else begin
          octet_d     = octet_next[7:0];
          digit_cnt_d = digit_cnt_q + 2'd1;
        end
      end else if (s_axis_tdata_i == ChDot) begin
        if (digit_cnt_q == 2'd0) begin
          err_d = StEmpty;
        end else if (dot_cnt_q == 2'd3) begin
          err_d = StDots;
        end else begin
          dot_cnt_d   = dot_cnt_q + 2'd1;
          octet_d     = 8'd0;
          digit_cnt_d = 2'd0;
        end
      end else begin
        err_d = StChar;
      end
    end
  end

  // Pick the final status, length first
  always_comb begin
    if (char_cnt_inc < LenMin || char_cnt_inc > LenMax) begin
      status_calc = StLength;
    end else if (err_d != StValid) begin
      status_calc = err_d;
    end else if (dot_cnt_d != 2'd3 || digit_cnt_d == 2'd0) begin
      status_calc = StForm;
    end else begin
      status_calc = StValid;
    end
  end

  // Result slot: load on the last character, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    if (in_acc && s_axis_tlast_i) begin
      out_valid_d = 1'b1;
      status_d    = status_calc;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold or advance the scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_cnt_q  <= '0;
      dot_cnt_q   <= '0;
      octet_q     <= '0;
      digit_cnt_q <= '0;
      err_q       <= StValid;
      out_valid_q <= 1'b0;
      status_q    <= StValid;
    end else begin
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      if (in_acc) begin
        if (s_axis_tlast_i) begin
          char_cnt_q  <= '0;
          dot_cnt_q   <= '0;
          octet_q     <= '0;
          digit_cnt_q <= '0;
          err_q       <= StValid;
        end else begin
          char_cnt_q  <= char_cnt_inc;
          dot_cnt_q   <= dot_cnt_d;
          octet_q     <= octet_d;
          digit_cnt_q <= digit_cnt_d;
          err_q       <= err_d;
        end
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, status_q};

  // A last character always leaves a status waiting
  a_last_gives_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("no status after last character");

  // A last character returns the scan to its start
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast_i |=> char_cnt_q == 5'd0 && err_q == StValid
      && dot_cnt_q == 2'd0 && digit_cnt_q == 2'd0)
    else $error("scan state not cleared after last character");

  // Once an error is held, the octet scan is frozen
  a_error_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tlast_i && err_q != StValid
      |=> $stable(dot_cnt_q) && $stable(octet_q) && $stable(digit_cnt_q)
        && $stable(err_q))
    else $error("scan state moved after an error");

  // Character count never passes saturation
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_cnt_q <= LenSat)
    else $error("character count past saturation");

  // A waiting status is never overwritten while stalled
  a_status_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> !in_acc || !s_axis_tlast_i
      || $past(status_q) == status_q)
    else $error("waiting status overwritten");

endmodule

`default_nettype wire

// ----- verif/ipv4_dotted_quad_checker_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for ipv4_dotted_quad_checker_unit: directed address table, then random
// addresses, each status word scored against the table or a scan-state predictor. Depends on ipv4dq_pkg.

module ipv4_dotted_quad_checker_unit_test;
  import ipv4dq_pkg::*;

  typedef logic [7:0] text_q_t[$];

  localparam int unsigned DecRadix  = 10;
  localparam int          RandItems = 1380;
  localparam int          CalmItems = 250;   // closing stretch without idling
  localparam int          NumProbes = 27;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       char_valid = 1'b0;
  logic       char_ready;
  logic [7:0] char_data = 8'h00;
  logic       char_last = 1'b0;
  logic       status_valid;
  logic       status_ready = 1'b0;
  logic [7:0] status_data;

  // Predictor scan state
  logic [4:0] scan_len    = '0;
  logic [1:0] scan_dots   = '0;
  logic [8:0] scan_octet  = '0;
  logic [1:0] scan_digits = '0;
  status_e    scan_fault  = StValid;

  status_e want_status_q[$];
  int      fail_count = 0;
  int      chars_sent = 0;
  bit      tx_idle_on = 1'b1;
  bit      rx_idle_on = 1'b1;
  int      rx_hold    = 0;

  // Directed address table; the wanted status counts only where typed is set
  string      probe_text  [NumProbes] = '{
    "0.0.0.0", "255.255.255.255", "1.2.3.4", "100.200.250.199",
    "1.2.3", "x", "1.2.3.4.5.6.7.8.9", "1111111111111111111111111111111111111111",
    "192.168.001.1", "1.2.3.04", "256.1.1.1", "255.255.255.256",
    "1.1.1.1000", "12345678", "1..1.1.1", ".1.1.1.1", "1.1.1.1.1", "1.1.1.1.",
    "1.1.1.a", "/.0.0.0.0", ":0.0.0.0", "1.2.3.4", "1.2.3.4", "1.2.3.4",
    "10.20.30", "1.22.33.", "0.0.0.00"
  };
  int         probe_raw_pos [NumProbes] = '{
    -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1,
    -1, -1, -1, 6, 0, 3, -1, -1, -1
  };
  logic [7:0] probe_raw_char[NumProbes] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00
  };
  bit         probe_typed [NumProbes] = '{
    1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 1, 1, 1, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1
  };
  status_e    probe_want  [NumProbes] = '{
    StValid, StValid, StValid, StValid, StLength, StLength, StLength, StLength,
    StLeadZero, StLeadZero, StOver, StOver, StValid, StValid, StEmpty, StEmpty,
    StDots, StValid, StChar, StChar, StChar, StChar, StChar, StChar,
    StForm, StForm, StLeadZero
  };

  ipv4_dotted_quad_checker_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (char_valid),
    .s_axis_tready_o (char_ready),
    .s_axis_tdata_i  (char_data),
    .s_axis_tlast_i  (char_last),
    .m_axis_tvalid_o (status_valid),
    .m_axis_tready_i (status_ready),
    .m_axis_tdata_o  (status_data)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advance the scan state by one character; give the status on the last one
  task automatic scan_char(input logic [7:0] ch, input logic is_last,
                           output status_e result);
    logic [11:0] next_val;
    next_val = '0;
    if (scan_len < LenSat) scan_len = scan_len + 5'd1;
    if (scan_fault == StValid) begin
      if (ch >= ChZero && ch <= ChNine) begin
        next_val = {3'b000, scan_octet} * DecRadix[11:0] + {4'b0000, ch - ChZero};
        if (scan_digits == 2'd1 && scan_octet == '0) begin
          scan_fault = StLeadZero;
        end else if (next_val > OctetMax) begin
          scan_fault = StOver;
        end else if (scan_digits == 2'd3) begin
          scan_fault = StDigits;
        end else begin
          scan_octet  = next_val[8:0];
          scan_digits = scan_digits + 2'd1;
        end
      end else if (ch == ChDot) begin
        if (scan_digits == 2'd0) begin
          scan_fault = StEmpty;
        end else if (scan_dots == 2'd3) begin
          scan_fault = StDots;
        end else begin
          scan_dots   = scan_dots + 2'd1;
          scan_octet  = '0;
          scan_digits = '0;
        end
      end else begin
        scan_fault = StChar;
      end
    end
    // Length outranks every other fault
    if (scan_len < LenMin || scan_len > LenMax) result = StLength;
    else if (scan_fault != StValid)             result = scan_fault;
    else if (scan_dots != 2'd3 || scan_digits == 2'd0) result = StForm;
    else                                        result = StValid;
    if (is_last) begin
      scan_len    = '0;
      scan_dots   = '0;
      scan_octet  = '0;
      scan_digits = '0;
      scan_fault  = StValid;
    end
  endtask

  // Offer one character word from a falling edge; predict once it is taken
  task automatic send_char(input logic [7:0] ch, input logic is_last,
                           input bit typed, input status_e typed_want);
    status_e result;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    char_valid <= 1'b1;
    char_data  <= ch;
    char_last  <= is_last;
    @(posedge clk_i);
    while (!char_ready) @(posedge clk_i);
    scan_char(ch, is_last, result);
    if (is_last) want_status_q.push_back(typed ? typed_want : result);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_address(input text_q_t text, input bit typed, input status_e want);
    int k;
    for (k = 0; k < text.size(); k++)
      send_char(text[k], k == text.size() - 1, typed, want);
  endtask

  // Hold the sender off until every pending status has come back
  task automatic drain_status;
    char_valid <= 1'b0;
    do @(negedge clk_i); while (want_status_q.size() != 0);
  endtask

  function automatic int rand_octet();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(1, 9);
      3:       return $urandom_range(10, 99);
      default: return $urandom_range(100, 255);
    endcase
  endfunction

  // Half well-formed addresses with random octets, the rest broken or noise
  task automatic build_address(output text_q_t text);
    string oct [4];
    string s;
    int    kind, pick, k, n_oct;
    n_oct = 4;
    for (k = 0; k < 4; k++) oct[k] = $sformatf("%0d", rand_octet());
    kind = $urandom_range(0, 23);
    pick = $urandom_range(0, 3);
    case (kind)
      12: oct[pick] = {"0", oct[pick]};
      13: oct[pick] = $sformatf("%0d", $urandom_range(256, 999));
      14: oct[pick] = $sformatf("%0d", $urandom_range(1000, 99999));
      15: oct[pick] = "";
      16: n_oct = $urandom_range(1, 3);
      default: ;
    endcase
    s = oct[0];
    for (k = 1; k < n_oct; k++) s = {s, ".", oct[k]};
    case (kind)
      17: s = {s, ".", oct[pick]};
      18: s = {s, "."};
      19: s = s.substr(0, $urandom_range(0, s.len() - 2));
      default: ;
    endcase
    text = {};
    for (k = 0; k < s.len(); k++) text.push_back(s[k]);
    case (kind)
      // stray byte anywhere in the text
      20: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      // random tail, often past the length limit
      21: repeat ($urandom_range(1, 24)) text.push_back(8'($urandom_range(0, 255)));
      // pure noise
      22: begin
        text = {};
        repeat ($urandom_range(1, 20)) text.push_back(8'($urandom_range(0, 255)));
      end
      // digits and dots padded on, often past the length limit
      23: repeat ($urandom_range(1, 12))
            text.push_back($urandom_range(0, 1) ? ChDot : 8'(ChZero + $urandom_range(0, 9)));
      default: ;
    endcase
    if (text.size() == 0) text.push_back(ChZero);
  endtask

  // Status-side back-pressure in bursts
  always @(negedge clk_i) begin
    if (rx_hold != 0 && rx_idle_on) begin
      rx_hold = rx_hold - 1;
    end else begin
      status_ready <= !(rx_idle_on && $urandom_range(0, 2) == 0);
      rx_hold = $urandom_range(0, 15);
    end
  end

  // Score each status word against the oldest prediction
  always @(posedge clk_i) begin : check_status
    status_e want;
    if (rst_n && status_valid && status_ready) begin
      if (want_status_q.size() == 0) begin
        $display("%0t: unexpected status word, expected none, got %h", $time, status_data);
        fail_count++;
      end else begin
        want = want_status_q.pop_front();
        if (status_data[3:0] != want) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want, status_data[3:0]);
          fail_count++;
        end
        if (status_data[7:4] != 4'h0) begin
          $display("%0t: status padding mismatch, expected 0, got %h",
                   $time, status_data[7:4]);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    text_q_t text;
    int      idx, k, rand_start, addr_num, seg, last_seg;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    // Directed table
    for (idx = 0; idx < NumProbes; idx++) begin
      text = {};
      for (k = 0; k < probe_text[idx].len(); k++) text.push_back(probe_text[idx][k]);
      if (probe_raw_pos[idx] >= 0) text[probe_raw_pos[idx]] = probe_raw_char[idx];
      send_address(text, probe_typed[idx], probe_want[idx]);
    end
    drain_status();

    // Random addresses, idling switched per segment, calm at the close
    rand_start = chars_sent;
    addr_num   = 0;
    last_seg   = -1;
    while (chars_sent - rand_start < RandItems) begin
      seg = addr_num / 12;
      if (chars_sent - rand_start >= RandItems - CalmItems) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else if (seg != last_seg) begin
        tx_idle_on = $urandom_range(0, 2) != 0;
        rx_idle_on = $urandom_range(0, 2) != 0;
        last_seg   = seg;
      end
      if (addr_num == 60) drain_status();
      build_address(text);
      send_address(text, 1'b0, StValid);
      addr_num++;
    end

    // Wait out the last status words
    char_valid <= 1'b0;
    while (want_status_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
design/ipv4dq_pkg.sv
design/ipv4_dotted_quad_checker_unit.sv
verif/ipv4_dotted_quad_checker_unit_test.sv
